// File: design/csr_sparse_matvec_macros.svh
// Assertion helpers used by csr_sparse_matvec.
`ifndef CSR_SPARSE_MATVEC_MACROS_SVH
`define CSR_SPARSE_MATVEC_MACROS_SVH

// Same-cycle implication, checked on clk and held off during reset.
`define CSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and held off during reset.
`define CSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/csm_pkg.sv
package csm_pkg;

  localparam int VECTOR_DEPTH_DEF = 1024;
  localparam int MAX_ROWS_DEF     = 65536;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 10;
  localparam int VAL_W     = 32;
  localparam int ROWNUM_W  = 16;
  localparam int NROWS_W   = 17;
  localparam int ACC_W     = 64;
  localparam int FRAC_BITS = 16;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NZ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EMPTY = 2'd2;

  // Register index, taken from byte address bit 2.
  localparam logic REG_NUM_ROWS = 1'b0;

  localparam logic [NROWS_W-1:0] NUM_ROWS_RESET = 17'd1;

  // Item after the store read has been issued.
  typedef struct packed {
    logic                    valid;
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
    logic                    eor;
    logic                    hit;
  } csm_nz_t;

  // Finished row handed to the output stage.
  typedef struct packed {
    logic                emit;
    logic [ACC_W-1:0]    total;
    logic [ROWNUM_W-1:0] row;
  } csm_row_t;

endpackage

// File: design/csm_in_if.sv
interface csm_in_if;
  logic                             valid;
  logic                             ready;
  logic [csm_pkg::CMD_W-1:0]        command;
  logic [csm_pkg::IDX_W-1:0]        index;
  logic signed [csm_pkg::VAL_W-1:0] value;
  logic                             end_of_row;

  modport source (output valid, output command, output index, output value,
                  output end_of_row, input ready);
  modport sink (input valid, input command, input index, input value,
                input end_of_row, output ready);
endinterface

// File: design/csm_out_if.sv
interface csm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [csm_pkg::VAL_W-1:0]    row_sum;
  logic [csm_pkg::ROWNUM_W-1:0]        row_number;
  logic                                saturated;

  modport source (output valid, output row_sum, output row_number,
                  output saturated, input ready);
  modport sink (input valid, input row_sum, input row_number,
                input saturated, output ready);
endinterface

// File: design/csr_sparse_matvec.sv
// Channel  | Direction | Word
// in_ch    | in        | command, index, value, end_of_row
// out_ch   | out       | row_sum, row_number, saturated
// cfg_*    | in/out    | APB register port, num_rows at byte address 0
//
// One word is taken every cycle while in_ch.ready is high. A row sum for the
// word that ends its row passes input register, store read, multiply,
// accumulate, then the saturating output register.
// Reset is synchronous and active low; it clears the accumulator, row counter
// and num_rows (to 1). The vector store is not cleared and has no reset pass.
// in_ch.ready drops only while a finished row meets an output word not yet taken.
`include "csr_sparse_matvec_macros.svh"

module csr_sparse_matvec #(
  parameter int VECTOR_DEPTH = csm_pkg::VECTOR_DEPTH_DEF,
  parameter int MAX_ROWS     = csm_pkg::MAX_ROWS_DEF,
  localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  csm_in_if.sink                      in_ch,
  csm_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [csm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [csm_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [csm_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  logic [csm_pkg::NROWS_W-1:0] num_rows_r;
  logic                        cfg_sel_rows;

  logic                              v0_r;
  logic [csm_pkg::CMD_W-1:0]         cmd0_r;
  logic [csm_pkg::IDX_W-1:0]         idx0_r;
  logic signed [csm_pkg::VAL_W-1:0]  val0_r;
  logic                              eor0_r;
  logic                              hit0;
  logic                              adv, hold;
  logic                              ram_we;
  logic [csm_pkg::VAL_W-1:0]         x_rd;

  csm_pkg::csm_nz_t  s1_r;
  csm_pkg::csm_row_t row;

  // Configuration port.
  assign cfg_pready   = 1'b1;
  assign cfg_sel_rows = (cfg_paddr[2] == csm_pkg::REG_NUM_ROWS);
  assign cfg_prdata   = cfg_sel_rows ? csm_pkg::CFG_DW'(num_rows_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= csm_pkg::NUM_ROWS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_rows) begin
      num_rows_r <= cfg_pwdata[csm_pkg::NROWS_W-1:0];
    end
  end

  assign adv         = !hold;
  assign in_ch.ready = adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd0_r <= in_ch.command;
      idx0_r <= in_ch.index;
      val0_r <= in_ch.value;
      eor0_r <= in_ch.end_of_row;
    end
  end

  assign hit0   = (32'(idx0_r) < 32'(VECTOR_DEPTH));
  assign ram_we = adv && v0_r && (cmd0_r == csm_pkg::CMD_LOAD) && hit0;

  // A load writes at the edge before the next word reads, so no bypass is needed.
  csm_ram #(
    .WIDTH (csm_pkg::VAL_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(idx0_r)),
    .wdata (val0_r),
    .re    (adv),
    .raddr (AW'(idx0_r)),
    .rdata (x_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r.valid <= v0_r;
      s1_r.cmd   <= cmd0_r;
      s1_r.value <= val0_r;
      s1_r.eor   <= eor0_r;
      s1_r.hit   <= hit0;
    end
  end

  csm_mac #(
    .MAX_ROWS (MAX_ROWS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .num_rows (num_rows_r),
    .nz_i     (s1_r),
    .x_i      (x_rd),
    .row_o    (row)
  );

  csm_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .row_i  (row),
    .hold_o (hold),
    .out_ch (out_ch)
  );

  `CSM_ASSERT_NOW(a_stall_needs_full_out, !in_ch.ready, out_ch.valid && !out_ch.ready, "input stalled without a waiting output word")
  `CSM_ASSERT_NEXT(a_s1_follows_s0, adv, s1_r.valid == $past(v0_r), "read stage lost or invented a word")
  `CSM_ASSERT_NOW(a_out_from_row_end, $rose(out_ch.valid), $past(row.emit), "output word without a finished row")

endmodule

// File: design/csm_ram.sv
module csm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/csm_mac.sv
module csm_mac #(
  parameter int MAX_ROWS = csm_pkg::MAX_ROWS_DEF,
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic [csm_pkg::NROWS_W-1:0]   num_rows,
  input  csm_pkg::csm_nz_t              nz_i,
  input  logic [csm_pkg::VAL_W-1:0]     x_i,
  output csm_pkg::csm_row_t             row_o
);

  logic                              v2_r;
  logic [csm_pkg::CMD_W-1:0]         cmd2_r;
  logic                              eor2_r;
  logic signed [csm_pkg::ACC_W-1:0]  p2_r;
  logic signed [csm_pkg::VAL_W-1:0]  x_sel;

  logic [csm_pkg::ACC_W-1:0]   acc_r, acc_nxt, acc_sum;
  logic [RW-1:0]               row_cnt_r, row_cnt_nxt;
  logic [csm_pkg::NROWS_W-1:0] row_inc;
  logic                        emit2;
  csm_pkg::csm_row_t           row_r, row_nxt;

  // A column outside the store reads as zero.
  assign x_sel = nz_i.hit ? $signed(x_i) : '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd2_r <= nz_i.cmd;
      eor2_r <= nz_i.eor;
      p2_r   <= nz_i.value * x_sel;
    end
  end

  // Q32.32 product back to Q16.16, floor rounding.
  assign acc_sum = acc_r + csm_pkg::ACC_W'(p2_r >>> csm_pkg::FRAC_BITS);
  assign row_inc = csm_pkg::NROWS_W'(row_cnt_r) + csm_pkg::NROWS_W'(1);

  always_comb begin
    acc_nxt     = acc_r;
    row_cnt_nxt = row_cnt_r;
    emit2       = 1'b0;
    row_nxt     = '0;
    if (v2_r) begin
      case (cmd2_r)
        csm_pkg::CMD_NZ: begin
          acc_nxt = eor2_r ? '0 : acc_sum;
          emit2   = eor2_r;
        end
        csm_pkg::CMD_EMPTY: begin
          acc_nxt = '0;
          emit2   = 1'b1;
        end
        default: ;
      endcase
    end
    row_nxt.emit  = emit2;
    row_nxt.total = (cmd2_r == csm_pkg::CMD_NZ) ? acc_sum : acc_r;
    row_nxt.row   = csm_pkg::ROWNUM_W'(row_cnt_r);
    if (emit2) begin
      if ((row_inc >= num_rows) ||
          (row_inc >= csm_pkg::NROWS_W'(MAX_ROWS))) begin
        row_cnt_nxt = '0;
      end else begin
        row_cnt_nxt = RW'(row_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r       <= 1'b0;
      acc_r      <= '0;
      row_cnt_r  <= '0;
      row_r.emit <= 1'b0;
    end else if (adv) begin
      v2_r       <= nz_i.valid;
      acc_r      <= acc_nxt;
      row_cnt_r  <= row_cnt_nxt;
      row_r      <= row_nxt;
    end
  end

  assign row_o = row_r;

endmodule

// File: design/csm_out.sv
module csm_out (
  input  logic              clk,
  input  logic              rst_n,
  input  csm_pkg::csm_row_t row_i,
  output logic              hold_o,
  csm_out_if.source         out_ch
);

  logic                             out_valid_r;
  logic signed [csm_pkg::VAL_W-1:0] sum_r, sum_nxt;
  logic [csm_pkg::ROWNUM_W-1:0]     row_r;
  logic                             sat_r, sat_nxt;
  logic                             fits;

  // The sum fits when bits 63..31 are all equal.
  assign fits = (row_i.total[csm_pkg::ACC_W-1:csm_pkg::VAL_W-1] == '0) ||
                (row_i.total[csm_pkg::ACC_W-1:csm_pkg::VAL_W-1] == '1);

  always_comb begin
    sat_nxt = !fits;
    if (fits) begin
      sum_nxt = $signed(row_i.total[csm_pkg::VAL_W-1:0]);
    end else if (row_i.total[csm_pkg::ACC_W-1]) begin
      sum_nxt = {1'b1, {(csm_pkg::VAL_W-1){1'b0}}};
    end else begin
      sum_nxt = {1'b0, {(csm_pkg::VAL_W-1){1'b1}}};
    end
  end

  // Only a finished row that finds the output word still waiting stops the pipe.
  assign hold_o = out_valid_r && !out_ch.ready && row_i.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (row_i.emit && !hold_o) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_i.emit && !hold_o) begin
      sum_r <= sum_nxt;
      row_r <= row_i.row;
      sat_r <= sat_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.row_sum    = sum_r;
  assign out_ch.row_number = row_r;
  assign out_ch.saturated  = sat_r;

endmodule
